### hdl/iat_pkg.sv
// Package for the indentation-aware tokenizer: codes, constants, command and
// status structs shared by the controller and the datapath.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package iat_pkg;

  localparam int MAX_DEPTH = 32;
  localparam int LVL_W     = $clog2(MAX_DEPTH);

  localparam logic [30:0] NUM_MAX = 31'h7FFF_FFFF;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_SP     = 8'h20;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_DASH   = 8'h2D;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_UP_A   = 8'h41;
  localparam logic [7:0] CH_UP_Z   = 8'h5A;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_USCORE = 8'h5F;
  localparam logic [7:0] CH_LO_A   = 8'h61;
  localparam logic [7:0] CH_LO_E   = 8'h65;
  localparam logic [7:0] CH_LO_F   = 8'h66;
  localparam logic [7:0] CH_LO_I   = 8'h69;
  localparam logic [7:0] CH_LO_L   = 8'h6C;
  localparam logic [7:0] CH_LO_Z   = 8'h7A;

  localparam logic [2:0] KW_START = 3'd0;
  localparam logic [2:0] KW_I     = 3'd1;
  localparam logic [2:0] KW_IF    = 3'd2;
  localparam logic [2:0] KW_E     = 3'd3;
  localparam logic [2:0] KW_EL    = 3'd4;
  localparam logic [2:0] KW_ELI   = 3'd5;
  localparam logic [2:0] KW_ELIF  = 3'd6;
  localparam logic [2:0] KW_DEAD  = 3'd7;

  typedef enum logic [3:0] {
    M_BOL, M_BOLCOM, M_MID, M_DASH, M_NAME, M_NAMEHY, M_NUM, M_CONDSKIP, M_COND, M_ERR
  } scan_mode_t;

  typedef enum logic [2:0] {
    PH_IDLE, PH_STEP, PH_SRCH, PH_DED, PH_ENDDED
  } phase_t;

  typedef enum logic [4:0] {
    TK_END, TK_NEWLINE, TK_INDENT, TK_DEDENT, TK_LBRACK, TK_RBRACK, TK_LPAREN,
    TK_RPAREN, TK_COLON, TK_SEMI, TK_COMMA, TK_ARROW, TK_STAR, TK_NAME, TK_NUMBER,
    TK_COND, TK_ERROR
  } tok_kind_t;

  typedef enum logic [2:0] {
    ER_NONE, ER_CHAR, ER_DEEP, ER_MISMATCH, ER_NOCOLON
  } err_code_t;

  typedef enum logic {SS_OFF, SS_OPEN} start_sel_t;

  typedef enum logic [2:0] {
    LS_ZERO, LS_ONE, LS_TWO, LS_OFF, LS_OFFM1, LS_COND
  } len_sel_t;

  typedef struct packed {
    logic       emit;
    tok_kind_t  kind;
    err_code_t  err;
    start_sel_t ssel;
    len_sel_t   lsel;
    logic       consume;
    logic       col_inc;
    logic       col_clr;
    logic       line_inc;
    logic       open_off;
    logic       open_offm1;
    logic       cond_off;
    logic       cond_off1;
    logic       num_load;
    logic       num_acc;
    logic       kw_load;
    logic       kw_adv;
    logic       kw_dead;
    logic       fol_set;
    logic       push;
    logic       srch_start;
    logic       srch_dec;
    logic       lvl_dec;
    logic       top_col;
  } iat_cmd_t;

  typedef struct packed {
    logic      is_blank;
    logic      is_lf;
    logic      is_hash;
    logic      is_zero;
    logic      is_dash;
    logic      is_gt;
    logic      is_colon;
    logic      punct;
    tok_kind_t punct_kind;
    logic      name_first;
    logic      name_more;
    logic      is_digit;
    logic      kw_cond;
    logic      col_gt_top;
    logic      col_lt_top;
    logic      push_ok;
    logic      srch_more;
    logic      srch_match;
    logic      lvl_gt_k;
    logic      lvl_nz;
    logic      can_emit;
  } iat_sts_t;

  typedef struct packed {
    tok_kind_t   kind;
    err_code_t   err;
    logic [30:0] val;
    logic [31:0] start;
    logic [31:0] len;
    logic [31:0] line;
    logic        last;
  } iat_tok_t;

  function automatic logic [2:0] kw_advance(input logic [2:0] p, input logic [7:0] c);
    logic [2:0] r;
    r = KW_DEAD;
    case (p)
      KW_START: begin
        if (c == CH_LO_I) r = KW_I;
        else if (c == CH_LO_E) r = KW_E;
      end
      KW_I:   if (c == CH_LO_F) r = KW_IF;
      KW_E:   if (c == CH_LO_L) r = KW_EL;
      KW_EL:  if (c == CH_LO_I) r = KW_ELI;
      KW_ELI: if (c == CH_LO_F) r = KW_ELIF;
      default: r = KW_DEAD;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

### hdl/iat_if.sv
// Channel interfaces for the tokenizer: text byte input and token output.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
interface iat_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  modport source (output valid, output text_byte, input ready);
  modport sink (input valid, input text_byte, output ready);
endinterface

interface iat_out_if;
  logic        valid;
  logic        ready;
  logic [4:0]  token_kind;
  logic [2:0]  error_code;
  logic [30:0] number_value;
  logic [31:0] token_start;
  logic [31:0] token_length;
  logic [31:0] line_number;
  logic        last_of_run;
  modport source (output valid, output token_kind, output error_code, output number_value,
                  output token_start, output token_length, output line_number,
                  output last_of_run, input ready);
  modport sink (input valid, input token_kind, input error_code, input number_value,
                input token_start, input token_length, input line_number,
                input last_of_run, output ready);
endinterface
`default_nettype wire

### hdl/iat_dp.sv
// Tokenizer datapath: held byte, counters, indentation stack, token staging and
// output register. Depends on iat_pkg.
`timescale 1ns / 1ps
`default_nettype none
module iat_dp
  import iat_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_acc,
  input  wire logic [7:0]  in_byte,
  input  wire iat_cmd_t    cmd,
  output iat_sts_t         sts,
  input  wire logic        out_ready,
  output logic             out_valid,
  output iat_tok_t         out_tok
);

  logic [7:0]       c_r;
  logic [31:0]      off_r, open_r, cond_r, line_r;
  logic [30:0]      acc_r;
  logic [15:0]      col_r, top_r;
  logic [2:0]       kw_r;
  logic             fol_r;
  logic [LVL_W-1:0] lvl_r, k_r;
  logic [15:0]      stk_r [MAX_DEPTH];
  logic             pend_v_r, out_v_r;
  iat_tok_t         pend_r, out_r;

  logic             alpha, digit, blank;
  logic [LVL_W-1:0] lvl_p1;
  logic [LVL_W:0]   lvl_ext;
  logic [15:0]      stk_rd;
  logic [34:0]      acc10;
  logic [30:0]      acc_sat;
  logic             slot_free, move;
  logic             zero_done;
  iat_tok_t         new_tok;

  assign alpha = (c_r >= CH_LO_A && c_r <= CH_LO_Z) || (c_r >= CH_UP_A && c_r <= CH_UP_Z);
  assign digit = c_r >= CH_ZERO && c_r <= CH_NINE;
  assign blank = c_r == CH_SP || c_r == CH_TAB;

  assign lvl_p1  = lvl_r + 1'b1;
  assign lvl_ext = {1'b0, lvl_r} + 1'b1;
  assign stk_rd  = (k_r == '0) ? 16'd0 : stk_r[k_r];

  assign acc10   = ({4'd0, acc_r} << 3) + ({4'd0, acc_r} << 1) + {31'd0, c_r[3:0]};
  assign acc_sat = (acc10 > {4'd0, NUM_MAX}) ? NUM_MAX : acc10[30:0];

  always_comb begin
    sts = '0;
    sts.is_blank   = blank;
    sts.is_lf      = c_r == CH_LF;
    sts.is_hash    = c_r == CH_HASH;
    sts.is_zero    = c_r == CH_NUL;
    sts.is_dash    = c_r == CH_DASH;
    sts.is_gt      = c_r == CH_GT;
    sts.is_colon   = c_r == CH_COLON;
    sts.punct      = 1'b1;
    unique case (c_r)
      CH_LBRACK: sts.punct_kind = TK_LBRACK;
      CH_RBRACK: sts.punct_kind = TK_RBRACK;
      CH_LPAREN: sts.punct_kind = TK_LPAREN;
      CH_RPAREN: sts.punct_kind = TK_RPAREN;
      CH_COLON:  sts.punct_kind = TK_COLON;
      CH_SEMI:   sts.punct_kind = TK_SEMI;
      CH_COMMA:  sts.punct_kind = TK_COMMA;
      CH_STAR:   sts.punct_kind = TK_STAR;
      default: begin
        sts.punct      = 1'b0;
        sts.punct_kind = TK_END;
      end
    endcase
    sts.name_first = alpha || c_r == CH_USCORE || c_r == CH_DOT;
    sts.name_more  = alpha || digit || c_r == CH_USCORE || c_r == CH_DOT ||
                     c_r == CH_DOLLAR || c_r == CH_PLUS;
    sts.is_digit   = digit;
    sts.kw_cond    = fol_r && (kw_r == KW_IF || kw_r == KW_ELIF);
    sts.col_gt_top = col_r > top_r;
    sts.col_lt_top = col_r < top_r;
    sts.push_ok    = lvl_ext < (LVL_W + 1)'(MAX_DEPTH);
    sts.srch_more  = (k_r != '0) && (stk_rd > col_r);
    sts.srch_match = stk_rd == col_r;
    sts.lvl_gt_k   = lvl_r > k_r;
    sts.lvl_nz     = lvl_r != '0;
    sts.can_emit   = !pend_v_r || slot_free;
  end

  always_comb begin
    new_tok       = '0;
    new_tok.kind  = cmd.kind;
    new_tok.err   = cmd.err;
    new_tok.val   = (cmd.kind == TK_NUMBER) ? acc_r : 31'd0;
    new_tok.start = (cmd.ssel == SS_OPEN) ? open_r : off_r;
    new_tok.line  = line_r;
    new_tok.last  = cmd.consume;
    case (cmd.lsel)
      LS_ZERO:  new_tok.len = 32'd0;
      LS_ONE:   new_tok.len = 32'd1;
      LS_TWO:   new_tok.len = 32'd2;
      LS_OFF:   new_tok.len = off_r - open_r;
      LS_OFFM1: new_tok.len = off_r - 32'd1 - open_r;
      LS_COND:  new_tok.len = cond_r - open_r;
      default:  new_tok.len = 32'd0;
    endcase
  end

  assign slot_free = !out_v_r || out_ready;
  assign move      = pend_v_r && slot_free && (pend_r.last || cmd.emit);
  assign zero_done = cmd.consume && c_r == CH_NUL;

  always_ff @(posedge clk) begin
    if (in_acc) begin
      c_r <= in_byte;
    end
    if (cmd.push) begin
      stk_r[lvl_p1] <= col_r;
    end
    if (cmd.emit) begin
      pend_r <= new_tok;
    end else if (cmd.consume) begin
      pend_r.last <= 1'b1;
    end
    if (move) begin
      out_r <= pend_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      if (cmd.emit) begin
        pend_v_r <= 1'b1;
      end else if (move) begin
        pend_v_r <= 1'b0;
      end
      if (move) begin
        out_v_r <= 1'b1;
      end else if (out_ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || zero_done) begin
      off_r  <= '0;
      open_r <= '0;
      cond_r <= '0;
      line_r <= 32'd1;
      acc_r  <= '0;
      col_r  <= '0;
      top_r  <= '0;
      kw_r   <= KW_START;
      fol_r  <= 1'b1;
      lvl_r  <= '0;
      k_r    <= '0;
    end else begin
      if (cmd.consume) off_r <= off_r + 32'd1;
      if (cmd.open_off) open_r <= off_r;
      if (cmd.open_offm1) open_r <= off_r - 32'd1;
      if (cmd.cond_off) cond_r <= off_r;
      if (cmd.cond_off1) cond_r <= off_r + 32'd1;
      if (cmd.line_inc) line_r <= line_r + 32'd1;
      if (cmd.num_load) acc_r <= {27'd0, c_r[3:0]};
      if (cmd.num_acc) acc_r <= acc_sat;
      if (cmd.col_clr) begin
        col_r <= '0;
      end else if (cmd.col_inc && col_r != 16'hFFFF) begin
        col_r <= col_r + 16'd1;
      end
      if (cmd.kw_load) kw_r <= kw_advance(KW_START, c_r);
      if (cmd.kw_adv) kw_r <= kw_advance(kw_r, c_r);
      if (cmd.kw_dead) kw_r <= KW_DEAD;
      if (cmd.emit && cmd.kind >= TK_LBRACK) begin
        fol_r <= 1'b0;
      end else if (cmd.fol_set) begin
        fol_r <= 1'b1;
      end
      if (cmd.push) begin
        lvl_r <= lvl_p1;
        top_r <= col_r;
      end
      if (cmd.top_col) top_r <= col_r;
      if (cmd.lvl_dec) lvl_r <= lvl_r - 1'b1;
      if (cmd.srch_start) k_r <= lvl_r;
      if (cmd.srch_dec) k_r <= k_r - 1'b1;
    end
  end

  assign out_valid = out_v_r;
  assign out_tok   = out_r;

endmodule
`default_nettype wire

### hdl/iat_ctrl.sv
// Tokenizer controller: scan mode and work phase state machine issuing
// commands to the datapath. Depends on iat_pkg.
`timescale 1ns / 1ps
`default_nettype none
module iat_ctrl
  import iat_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire iat_sts_t sts,
  output iat_cmd_t      cmd
);

  scan_mode_t mode_r, mode_nxt, mode_req;
  phase_t     phase_r, phase_nxt, phase_req;
  iat_cmd_t   cmd_raw;
  logic       stall;

  function automatic iat_cmd_t mk_tok(input tok_kind_t k, input err_code_t e,
                                      input start_sel_t s, input len_sel_t l);
    iat_cmd_t r;
    r      = '0;
    r.emit = 1'b1;
    r.kind = k;
    r.err  = e;
    r.ssel = s;
    r.lsel = l;
    return r;
  endfunction

  always_comb begin
    cmd_raw   = '0;
    mode_req  = mode_r;
    phase_req = phase_r;
    unique case (phase_r)
      PH_IDLE: begin
        phase_req = PH_IDLE;
      end
      PH_STEP: begin
        case (mode_r)
          M_BOL: begin
            if (sts.is_blank) begin
              cmd_raw.col_inc = 1'b1;
              cmd_raw.consume = 1'b1;
            end else if (sts.is_lf) begin
              cmd_raw.line_inc = 1'b1;
              cmd_raw.col_clr  = 1'b1;
              cmd_raw.consume  = 1'b1;
            end else if (sts.is_hash) begin
              mode_req        = M_BOLCOM;
              cmd_raw.consume = 1'b1;
            end else if (sts.is_zero) begin
              phase_req = PH_ENDDED;
            end else if (sts.col_gt_top) begin
              if (!sts.push_ok) begin
                cmd_raw         = mk_tok(TK_ERROR, ER_DEEP, SS_OFF, LS_ZERO);
                cmd_raw.consume = 1'b1;
                mode_req        = M_ERR;
              end else begin
                cmd_raw         = mk_tok(TK_INDENT, ER_NONE, SS_OFF, LS_ZERO);
                cmd_raw.push    = 1'b1;
                cmd_raw.fol_set = 1'b1;
                mode_req        = M_MID;
              end
            end else if (sts.col_lt_top) begin
              cmd_raw.srch_start = 1'b1;
              phase_req          = PH_SRCH;
            end else begin
              cmd_raw.fol_set = 1'b1;
              mode_req        = M_MID;
            end
          end
          M_BOLCOM: begin
            if (sts.is_lf) begin
              cmd_raw.line_inc = 1'b1;
              cmd_raw.col_clr  = 1'b1;
              cmd_raw.consume  = 1'b1;
              mode_req         = M_BOL;
            end else if (sts.is_zero) begin
              phase_req = PH_ENDDED;
            end else begin
              cmd_raw.consume = 1'b1;
            end
          end
          M_MID: begin
            if (sts.is_blank) begin
              cmd_raw.consume = 1'b1;
            end else if (sts.is_lf) begin
              cmd_raw          = mk_tok(TK_NEWLINE, ER_NONE, SS_OFF, LS_ONE);
              cmd_raw.line_inc = 1'b1;
              cmd_raw.col_clr  = 1'b1;
              cmd_raw.consume  = 1'b1;
              mode_req         = M_BOL;
            end else if (sts.is_hash) begin
              cmd_raw         = mk_tok(TK_NEWLINE, ER_NONE, SS_OFF, LS_ZERO);
              cmd_raw.consume = 1'b1;
              mode_req        = M_BOLCOM;
            end else if (sts.is_zero) begin
              cmd_raw   = mk_tok(TK_NEWLINE, ER_NONE, SS_OFF, LS_ZERO);
              phase_req = PH_ENDDED;
            end else if (sts.is_dash) begin
              cmd_raw.open_off = 1'b1;
              cmd_raw.consume  = 1'b1;
              mode_req         = M_DASH;
            end else if (sts.punct) begin
              cmd_raw         = mk_tok(sts.punct_kind, ER_NONE, SS_OFF, LS_ONE);
              cmd_raw.consume = 1'b1;
            end else if (sts.name_first) begin
              cmd_raw.open_off = 1'b1;
              cmd_raw.kw_load  = 1'b1;
              cmd_raw.consume  = 1'b1;
              mode_req         = M_NAME;
            end else if (sts.is_digit) begin
              cmd_raw.open_off = 1'b1;
              cmd_raw.num_load = 1'b1;
              cmd_raw.consume  = 1'b1;
              mode_req         = M_NUM;
            end else begin
              cmd_raw         = mk_tok(TK_ERROR, ER_CHAR, SS_OFF, LS_ONE);
              cmd_raw.consume = 1'b1;
              mode_req        = M_ERR;
            end
          end
          M_DASH: begin
            if (sts.is_gt) begin
              cmd_raw  = mk_tok(TK_ARROW, ER_NONE, SS_OPEN, LS_TWO);
              mode_req = M_MID;
            end else begin
              cmd_raw  = mk_tok(TK_ERROR, ER_CHAR, SS_OPEN, LS_ONE);
              mode_req = M_ERR;
            end
            cmd_raw.consume = 1'b1;
          end
          M_NAME: begin
            if (sts.name_more) begin
              cmd_raw.kw_adv  = 1'b1;
              cmd_raw.consume = 1'b1;
            end else if (sts.is_dash) begin
              cmd_raw.consume = 1'b1;
              mode_req        = M_NAMEHY;
            end else begin
              cmd_raw  = mk_tok(TK_NAME, ER_NONE, SS_OPEN, LS_OFF);
              mode_req = sts.kw_cond ? M_CONDSKIP : M_MID;
            end
          end
          M_NAMEHY: begin
            if (sts.name_more) begin
              cmd_raw.kw_dead = 1'b1;
              cmd_raw.consume = 1'b1;
              mode_req        = M_NAME;
            end else begin
              cmd_raw            = mk_tok(TK_NAME, ER_NONE, SS_OPEN, LS_OFFM1);
              cmd_raw.open_offm1 = 1'b1;
              if (sts.kw_cond) begin
                cmd_raw.cond_off = 1'b1;
                mode_req         = M_COND;
              end else begin
                mode_req = M_DASH;
              end
            end
          end
          M_NUM: begin
            if (sts.is_digit) begin
              cmd_raw.num_acc = 1'b1;
              cmd_raw.consume = 1'b1;
            end else begin
              cmd_raw  = mk_tok(TK_NUMBER, ER_NONE, SS_OPEN, LS_OFF);
              mode_req = M_MID;
            end
          end
          M_CONDSKIP: begin
            if (sts.is_blank) begin
              cmd_raw.consume = 1'b1;
            end else begin
              cmd_raw.open_off = 1'b1;
              cmd_raw.cond_off = 1'b1;
              mode_req         = M_COND;
            end
          end
          M_COND: begin
            if (sts.is_colon) begin
              cmd_raw  = mk_tok(TK_COND, ER_NONE, SS_OPEN, LS_COND);
              mode_req = M_MID;
            end else if (sts.is_lf || sts.is_zero) begin
              cmd_raw  = mk_tok(TK_ERROR, ER_NOCOLON, SS_OFF, LS_ZERO);
              mode_req = M_ERR;
            end else if (!sts.is_blank) begin
              cmd_raw.cond_off1 = 1'b1;
            end
            cmd_raw.consume = 1'b1;
          end
          default: begin
            cmd_raw.consume = 1'b1;
          end
        endcase
      end
      PH_SRCH: begin
        if (sts.srch_more) begin
          cmd_raw.srch_dec = 1'b1;
        end else if (!sts.srch_match) begin
          cmd_raw         = mk_tok(TK_ERROR, ER_MISMATCH, SS_OFF, LS_ZERO);
          cmd_raw.consume = 1'b1;
          mode_req        = M_ERR;
        end else begin
          phase_req = PH_DED;
        end
      end
      PH_DED: begin
        if (sts.lvl_gt_k) begin
          cmd_raw         = mk_tok(TK_DEDENT, ER_NONE, SS_OFF, LS_ZERO);
          cmd_raw.lvl_dec = 1'b1;
        end else begin
          cmd_raw.top_col = 1'b1;
          cmd_raw.fol_set = 1'b1;
          mode_req        = M_MID;
          phase_req       = PH_STEP;
        end
      end
      PH_ENDDED: begin
        if (sts.lvl_nz) begin
          cmd_raw         = mk_tok(TK_DEDENT, ER_NONE, SS_OFF, LS_ZERO);
          cmd_raw.lvl_dec = 1'b1;
        end else begin
          cmd_raw         = mk_tok(TK_END, ER_NONE, SS_OFF, LS_ZERO);
          cmd_raw.consume = 1'b1;
        end
      end
      default: begin
        phase_req = PH_IDLE;
      end
    endcase
  end

  assign stall = cmd_raw.emit && !sts.can_emit;

  always_comb begin
    mode_nxt  = mode_r;
    phase_nxt = phase_r;
    if (!stall) begin
      mode_nxt  = mode_req;
      phase_nxt = phase_req;
    end
    if (cmd.consume) begin
      phase_nxt = in_valid ? PH_STEP : PH_IDLE;
      if (sts.is_zero) mode_nxt = M_BOL;
    end else if (phase_r == PH_IDLE && in_valid) begin
      phase_nxt = PH_STEP;
    end
  end

  always_comb begin
    cmd      = stall ? '0 : cmd_raw;
    in_ready = (phase_r == PH_IDLE) || cmd.consume;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= M_BOL;
      phase_r <= PH_IDLE;
    end else begin
      mode_r  <= mode_nxt;
      phase_r <= phase_nxt;
    end
  end

endmodule
`default_nettype wire

### hdl/indent_aware_tokenizer_top.sv
// Top level of the indentation-aware tokenizer: controller plus datapath.
// Depends on iat_pkg, iat_if, iat_ctrl and iat_dp.
//
//   channel    direction  handshake     payload
//   in_chan    sink       valid/ready   text_byte
//   out_chan   source     valid/ready   token fields, last_of_run
//
// A byte is taken when the previous one is finished and is worked on one step a cycle
// unless a step waits to make a token, each step making at most one token; most bytes take
// one step. Extra steps go to the first non-blank byte of a line and to a byte that closes a
// name, a number, a name hyphen or a condition skip. A line start that closes levels first
// searches the stack, then makes one dedent per level; byte 0 makes one per open level.
// Reset is synchronous and active low and returns the tokenizer to a line start.
// A step that makes a token waits while the staging slot and the output register are
// both full; a token waits in the output register while the next byte is taken.
`timescale 1ns / 1ps
`default_nettype none
module indent_aware_tokenizer_top
  import iat_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  iat_in_if.sink    in_chan,
  iat_out_if.source out_chan
);

  iat_cmd_t cmd;
  iat_sts_t sts;
  iat_tok_t tok;
  logic     in_ready;
  logic     out_valid;

  iat_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  iat_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_acc    (in_chan.valid && in_ready),
    .in_byte   (in_chan.text_byte),
    .cmd       (cmd),
    .sts       (sts),
    .out_ready (out_chan.ready),
    .out_valid (out_valid),
    .out_tok   (tok)
  );

  assign in_chan.ready         = in_ready;
  assign out_chan.valid        = out_valid;
  assign out_chan.token_kind   = tok.kind;
  assign out_chan.error_code   = tok.err;
  assign out_chan.number_value = tok.val;
  assign out_chan.token_start  = tok.start;
  assign out_chan.token_length = tok.len;
  assign out_chan.line_number  = tok.line;
  assign out_chan.last_of_run  = tok.last;

endmodule
`default_nettype wire

### hdl/iat_chk.sv
// Port-level checker for the tokenizer, bound to the top level.
// Depends on iat_pkg.
`timescale 1ns / 1ps
`default_nettype none
module iat_chk
  import iat_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [4:0]  token_kind,
  input wire logic [2:0]  error_code,
  input wire logic [30:0] number_value,
  input wire logic [31:0] line_number
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("output transfer dropped while stalled");

  a_line_nz: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> line_number != 32'd0)
    else $error("line number is zero");

  a_err_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((token_kind == TK_ERROR) == (error_code != ER_NONE)))
    else $error("error code does not match token kind");

  a_num_val: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && token_kind != TK_NUMBER |-> number_value == 31'd0)
    else $error("value on a token that is not a number");

endmodule

bind indent_aware_tokenizer_top iat_chk u_iat_chk (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_chan.valid),
  .out_ready    (out_chan.ready),
  .token_kind   (out_chan.token_kind),
  .error_code   (out_chan.error_code),
  .number_value (out_chan.number_value),
  .line_number  (out_chan.line_number)
);
`default_nettype wire

### tb/tokenizer_checker.sv
// Checker for the indentation-aware tokenizer: watches both channels, predicts
// the token stream of every accepted text byte and compares each token transfer.
// Depends on iat_pkg and iat_if.
`timescale 1ns / 1ps
module tokenizer_checker
  import iat_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  iat_in_if    in_chan,
  iat_out_if   out_chan,
  output int   fail_count,
  output int   tokens_pending
);

  logic [15:0] col_stack [MAX_DEPTH];
  int unsigned depth;
  scan_mode_t  mode;
  logic [31:0] line_no;
  logic [31:0] byte_pos;
  logic [31:0] tok_begin;
  logic [31:0] cond_end;
  logic [30:0] num_acc;
  logic [15:0] column;
  logic [2:0]  kw_state;
  logic        first_tok;

  iat_tok_t    byte_tokens[$];
  iat_tok_t    token_queue[$];

  function automatic bit blank_ch(logic [7:0] c);
    return c == CH_SP || c == CH_TAB;
  endfunction

  function automatic bit digit_ch(logic [7:0] c);
    return c >= CH_ZERO && c <= CH_NINE;
  endfunction

  function automatic bit alpha_ch(logic [7:0] c);
    return (c >= CH_LO_A && c <= CH_LO_Z) || (c >= CH_UP_A && c <= CH_UP_Z);
  endfunction

  function automatic bit starts_name(logic [7:0] c);
    return alpha_ch(c) || c == CH_USCORE || c == CH_DOT;
  endfunction

  function automatic bit continues_name(logic [7:0] c);
    return starts_name(c) || digit_ch(c) || c == CH_DOLLAR || c == CH_PLUS;
  endfunction

  function automatic logic [2:0] next_kw(logic [2:0] p, logic [7:0] c);
    case (p)
      KW_START: return c == CH_LO_I ? KW_I : (c == CH_LO_E ? KW_E : KW_DEAD);
      KW_I:     return c == CH_LO_F ? KW_IF : KW_DEAD;
      KW_E:     return c == CH_LO_L ? KW_EL : KW_DEAD;
      KW_EL:    return c == CH_LO_I ? KW_ELI : KW_DEAD;
      KW_ELI:   return c == CH_LO_F ? KW_ELIF : KW_DEAD;
      default:  return KW_DEAD;
    endcase
  endfunction

  function automatic void add_token(tok_kind_t k, err_code_t e, logic [30:0] v,
                                    logic [31:0] s, logic [31:0] l);
    iat_tok_t t;
    if (k >= TK_LBRACK) first_tok = 1'b0;
    if (byte_tokens.size() >= MAX_DEPTH + 2) return;
    t.kind = k;
    t.err = e;
    t.val = v;
    t.start = s;
    t.len = l;
    t.line = line_no;
    t.last = 1'b0;
    byte_tokens.push_back(t);
  endfunction

  function automatic void raise_error(err_code_t e, logic [31:0] s, logic [31:0] l);
    add_token(TK_ERROR, e, '0, s, l);
    mode = M_ERR;
  endfunction

  function automatic void close_text(logic [31:0] off);
    while (depth > 0) begin
      add_token(TK_DEDENT, ER_NONE, '0, off, 0);
      depth--;
    end
    add_token(TK_END, ER_NONE, '0, off, 0);
  endfunction

  function automatic bit apply_indent(logic [15:0] col, logic [31:0] off);
    int unsigned lvl;
    int unsigned k;
    lvl = depth % MAX_DEPTH;
    if (col > col_stack[lvl]) begin
      if (lvl + 1 >= MAX_DEPTH) begin
        raise_error(ER_DEEP, off, 0);
        return 0;
      end
      lvl++;
      col_stack[lvl] = col;
      depth = lvl;
      add_token(TK_INDENT, ER_NONE, '0, off, 0);
    end else if (col < col_stack[lvl]) begin
      k = lvl;
      while (k > 0 && col_stack[k] > col) k--;
      if (col_stack[k] != col) begin
        raise_error(ER_MISMATCH, off, 0);
        return 0;
      end
      while (lvl > k) begin
        add_token(TK_DEDENT, ER_NONE, '0, off, 0);
        lvl--;
      end
      depth = lvl;
    end
    return 1;
  endfunction

  function automatic void close_name(logic [31:0] stop);
    bit is_cond;
    is_cond = first_tok && (kw_state == KW_IF || kw_state == KW_ELIF);
    add_token(TK_NAME, ER_NONE, '0, tok_begin, stop - tok_begin);
    mode = is_cond ? M_CONDSKIP : M_MID;
  endfunction

  function automatic void scan(logic [7:0] c, logic [31:0] off);
    logic [31:0] d;
    case (mode)
      M_BOL: begin
        if (blank_ch(c)) begin
          if (column != 16'hFFFF) column++;
        end else if (c == CH_LF) begin
          line_no++;
          column = 0;
        end else if (c == CH_HASH) begin
          mode = M_BOLCOM;
        end else if (c == CH_NUL) begin
          close_text(off);
        end else if (apply_indent(column, off)) begin
          mode = M_MID;
          first_tok = 1'b1;
          scan(c, off);
        end
      end
      M_BOLCOM: begin
        if (c == CH_LF) begin
          line_no++;
          column = 0;
          mode = M_BOL;
        end else if (c == CH_NUL) begin
          close_text(off);
        end
      end
      M_MID: begin
        if (blank_ch(c)) return;
        case (c)
          CH_LF: begin
            add_token(TK_NEWLINE, ER_NONE, '0, off, 1);
            line_no++;
            column = 0;
            mode = M_BOL;
          end
          CH_HASH: begin
            add_token(TK_NEWLINE, ER_NONE, '0, off, 0);
            mode = M_BOLCOM;
          end
          CH_NUL: begin
            add_token(TK_NEWLINE, ER_NONE, '0, off, 0);
            close_text(off);
          end
          CH_DASH: begin
            tok_begin = off;
            mode = M_DASH;
          end
          CH_LBRACK: add_token(TK_LBRACK, ER_NONE, '0, off, 1);
          CH_RBRACK: add_token(TK_RBRACK, ER_NONE, '0, off, 1);
          CH_LPAREN: add_token(TK_LPAREN, ER_NONE, '0, off, 1);
          CH_RPAREN: add_token(TK_RPAREN, ER_NONE, '0, off, 1);
          CH_COLON:  add_token(TK_COLON, ER_NONE, '0, off, 1);
          CH_SEMI:   add_token(TK_SEMI, ER_NONE, '0, off, 1);
          CH_COMMA:  add_token(TK_COMMA, ER_NONE, '0, off, 1);
          CH_STAR:   add_token(TK_STAR, ER_NONE, '0, off, 1);
          default: begin
            tok_begin = off;
            if (starts_name(c)) begin
              kw_state = next_kw(KW_START, c);
              mode = M_NAME;
            end else if (digit_ch(c)) begin
              num_acc = 31'(c - CH_ZERO);
              mode = M_NUM;
            end else begin
              raise_error(ER_CHAR, off, 1);
            end
          end
        endcase
      end
      M_DASH: begin
        if (c == CH_GT) begin
          add_token(TK_ARROW, ER_NONE, '0, tok_begin, 2);
          mode = M_MID;
        end else begin
          raise_error(ER_CHAR, tok_begin, 1);
        end
      end
      M_NAME: begin
        if (continues_name(c)) begin
          kw_state = next_kw(kw_state, c);
        end else if (c == CH_DASH) begin
          mode = M_NAMEHY;
        end else begin
          close_name(off);
          scan(c, off);
        end
      end
      M_NAMEHY: begin
        if (continues_name(c)) begin
          kw_state = KW_DEAD;
          mode = M_NAME;
        end else begin
          close_name(off - 1);
          scan(CH_DASH, off - 1);
          scan(c, off);
        end
      end
      M_NUM: begin
        if (digit_ch(c)) begin
          d = 32'(c - CH_ZERO);
          if (32'(num_acc) > (32'(NUM_MAX) - d) / 10) num_acc = NUM_MAX;
          else num_acc = 31'(32'(num_acc) * 10 + d);
        end else begin
          add_token(TK_NUMBER, ER_NONE, num_acc, tok_begin, off - tok_begin);
          mode = M_MID;
          scan(c, off);
        end
      end
      M_CONDSKIP: begin
        if (blank_ch(c)) return;
        tok_begin = off;
        cond_end = off;
        mode = M_COND;
        scan(c, off);
      end
      M_COND: begin
        if (c == CH_COLON) begin
          add_token(TK_COND, ER_NONE, '0, tok_begin, cond_end - tok_begin);
          mode = M_MID;
        end else if (c == CH_LF || c == CH_NUL) begin
          raise_error(ER_NOCOLON, off, 0);
        end else if (!blank_ch(c)) begin
          cond_end = off + 1;
        end
      end
      default: ;
    endcase
  endfunction

  function automatic void clear_state();
    foreach (col_stack[i]) col_stack[i] = '0;
    depth = 0;
    mode = M_BOL;
    line_no = 1;
    byte_pos = 0;
    tok_begin = 0;
    cond_end = 0;
    num_acc = 0;
    column = 0;
    kw_state = KW_START;
    first_tok = 1'b1;
  endfunction

  function automatic void predict_byte(logic [7:0] c);
    byte_tokens.delete();
    scan(c, byte_pos);
    byte_pos++;
    if (c == CH_NUL) clear_state();
    if (byte_tokens.size() > 0) byte_tokens[byte_tokens.size() - 1].last = 1'b1;
    foreach (byte_tokens[i]) token_queue.push_back(byte_tokens[i]);
  endfunction

  always @(posedge clk) begin
    iat_tok_t want;
    if (!rst_n) begin
      clear_state();
      token_queue.delete();
      fail_count <= 0;
    end else begin
      if (in_chan.valid && in_chan.ready) predict_byte(in_chan.text_byte);
      if (out_chan.valid && out_chan.ready) begin
        if (token_queue.size() == 0) begin
          $display("%0t: unexpected token expected none actual kind=%0d start=%0d", $time,
                   out_chan.token_kind, out_chan.token_start);
          fail_count <= fail_count + 1;
        end else begin
          want = token_queue.pop_front();
          if (out_chan.token_kind !== want.kind || out_chan.error_code !== want.err ||
              out_chan.number_value !== want.val || out_chan.token_start !== want.start ||
              out_chan.token_length !== want.len || out_chan.line_number !== want.line ||
              out_chan.last_of_run !== want.last) begin
            $display("%0t: mismatch expected kind=%0d err=%0d val=%0d start=%0d len=%0d line=%0d last=%0d",
                     $time, want.kind, want.err, want.val, want.start, want.len,
                     want.line, want.last);
            $display("%0t:          actual   kind=%0d err=%0d val=%0d start=%0d len=%0d line=%0d last=%0d",
                     $time, out_chan.token_kind, out_chan.error_code,
                     out_chan.number_value, out_chan.token_start, out_chan.token_length,
                     out_chan.line_number, out_chan.last_of_run);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
    tokens_pending <= token_queue.size();
  end

endmodule

### tb/testbench.sv
// Top of the tokenizer testbench: clock, reset, text generation and handshake
// pacing; the verdict comes from the failure count of tokenizer_checker.
// Depends on iat_pkg, iat_if, indent_aware_tokenizer_top and tokenizer_checker.
`timescale 1ns / 1ps
module testbench;
  import iat_pkg::*;

  logic clk;
  logic rst_n;
  int   fail_count;
  int   tokens_pending;
  int   send_idle_pct;
  int   stall_pct;
  int   hold_requests;
  int   hold_served;
  int   hold_left;
  int   bytes_sent;
  logic [7:0] text_q[$];

  iat_in_if  in_chan();
  iat_out_if out_chan();

  indent_aware_tokenizer_top dut (.clk(clk), .rst_n(rst_n), .in_chan(in_chan),
                                  .out_chan(out_chan));

  tokenizer_checker u_checker (.clk(clk), .rst_n(rst_n), .in_chan(in_chan),
                               .out_chan(out_chan), .fail_count(fail_count),
                               .tokens_pending(tokens_pending));

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
    end else if (hold_served != hold_requests) begin
      hold_served = hold_requests;
      hold_left = 300;
      out_chan.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_chan.ready <= 1'b0;
    end else begin
      out_chan.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic send_byte(logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_chan.valid <= 1'b0;
      @(negedge clk);
    end
    in_chan.valid <= 1'b1;
    in_chan.text_byte <= b;
    do @(posedge clk); while (!in_chan.ready);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_text();
    while (text_q.size() > 0) send_byte(text_q.pop_front());
  endtask

  task automatic put_str(string s);
    for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
  endtask

  task automatic put_blanks(int n);
    for (int i = 0; i < n; i++) text_q.push_back($urandom_range(1) ? CH_SP : CH_TAB);
  endtask

  task automatic put_name();
    string pool;
    int n;
    pool = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_.0123456789$+";
    text_q.push_back(pool[$urandom_range(53)]);
    n = $urandom_range(4);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(7) == 0) text_q.push_back(CH_DASH);
      text_q.push_back(pool[$urandom_range(65)]);
    end
  endtask

  task automatic put_token();
    int n;
    string punct;
    punct = "[](),;*:";
    case ($urandom_range(9))
      0, 1, 2: put_name();
      3, 4: begin
        n = $urandom_range(3) == 0 ? $urandom_range(10, 13) : $urandom_range(1, 4);
        for (int i = 0; i < n; i++) text_q.push_back(8'(CH_ZERO + $urandom_range(9)));
      end
      5, 6: text_q.push_back(punct[$urandom_range(7)]);
      7: put_str("->");
      8: begin
        text_q.push_back(CH_DASH);
        if ($urandom_range(1)) text_q.push_back(CH_GT);
      end
      default: begin
        if ($urandom_range(4) == 0) text_q.push_back(8'($urandom_range(1, 255)));
        else put_name();
      end
    endcase
  endtask

  task automatic make_text();
    int cols[$];
    int lines;
    int col;
    int n;
    cols.push_back(0);
    lines = $urandom_range(2, 7);
    for (int ln = 0; ln < lines; ln++) begin
      n = $urandom_range(19);
      if (n == 0) begin
        put_blanks($urandom_range(3));
        text_q.push_back(CH_LF);
        continue;
      end
      if (n == 1) begin
        put_blanks($urandom_range(2));
        text_q.push_back(CH_HASH);
        for (int i = 0; i < $urandom_range(4); i++)
          text_q.push_back(8'($urandom_range(1, 255)));
        text_q.push_back(CH_LF);
        continue;
      end
      n = $urandom_range(9);
      if (n < 3) begin
        col = cols[$] + $urandom_range(1, 4);
        cols.push_back(col);
      end else if (n < 6 && cols.size() > 1) begin
        n = $urandom_range(1, cols.size() - 1);
        repeat (n) void'(cols.pop_back());
        col = cols[$];
      end else if (n == 9) begin
        col = $urandom_range(12);
      end else begin
        col = cols[$];
      end
      put_blanks(col);
      if ($urandom_range(4) == 0) begin
        put_str($urandom_range(1) ? "if" : "elif");
        put_blanks($urandom_range(2));
        for (int i = 0; i < $urandom_range(3); i++) begin
          put_token();
          put_blanks($urandom_range(2));
        end
        if ($urandom_range(9) != 0) text_q.push_back(CH_COLON);
      end
      n = $urandom_range(1, 5);
      for (int i = 0; i < n; i++) begin
        put_token();
        put_blanks($urandom_range(2) == 0 ? 1 : 0);
      end
      if ($urandom_range(5) == 0) put_str(" #x");
      if (ln != lines - 1 || $urandom_range(2) != 0) text_q.push_back(CH_LF);
    end
    text_q.push_back(CH_NUL);
  endtask

  task automatic run_phase(int idle_pct, int stall, int quota);
    int target;
    send_idle_pct = idle_pct;
    stall_pct = stall;
    target = bytes_sent + quota;
    while (bytes_sent < target) begin
      make_text();
      send_text();
    end
  endtask

  initial begin
    in_chan.valid = 1'b0;
    in_chan.text_byte = '0;
    out_chan.ready = 1'b0;
    rst_n = 1'b0;
    send_idle_pct = 0;
    stall_pct = 0;
    hold_requests = 0;
    hold_served = 0;
    hold_left = 0;
    bytes_sent = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    put_str("elif  p q: 7\n\t_a-b.c$+ #\n-x");
    text_q.push_back(CH_NUL);
    send_text();

    put_str("x 99999999999 [](),;*->\n");
    put_blanks(3);
    put_str("a\nb");
    text_q.push_back(CH_NUL);
    send_text();

    run_phase(0, 0, 30);
    run_phase(82, 0, 30);
    hold_requests++;
    send_idle_pct = 0;
    make_text();
    make_text();
    send_text();
    run_phase(0, 82, 30);
    run_phase(14, 14, 30);

    in_chan.valid <= 1'b0;
    stall_pct = 0;
    while (tokens_pending != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (fail_count == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

  initial begin
    #4000000;
    $display("Verification failed");
    $finish;
  end

endmodule
